[rtl/core/sphenic_number_classifier_top_macros.svh]
// assertion helpers for the sphenic number classifier
`ifndef SPHENIC_NUMBER_CLASSIFIER_TOP_MACROS_SVH
`define SPHENIC_NUMBER_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SNC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/snc_pkg.sv]
package snc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIRST_DIVISOR   = 2;
  localparam int SPHENIC_PRIMES  = 3;
  localparam int LEAST_SPHENIC   = 30;
  localparam int MULT_MAX        = 31;
  localparam int MULT_W          = 5;
  localparam int TALLY_W         = 4;
  localparam int OUT_TDATA_W     = 8;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/core/sphenic_number_classifier_top.sv]
// sphenic number classifier: trial division through a bit-serial divider
// sequence: each input takes one division per divisor tried and one more per
//   repeated factor hit, then waits in S_DONE until the output slot is free;
//   trial divisors run from two up to just past the square root of the cofactor
// throughput: one item at a time; the next input transfer can land as out_tvalid rises
// reset: synchronous active-low rst_n clears the sequencer, the divider control and out_tvalid
module sphenic_number_classifier_top #(
  parameter  int VALUE_WIDTH = snc_pkg::VALUE_WIDTH_DEF,
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: value [VALUE_WIDTH-1:0], zero pad above
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  // out_tdata: is_sphenic [0], square_free [1], distinct_primes [5:2], zero pad [7:6]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [snc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import snc_pkg::*;

  `include "sphenic_number_classifier_top_macros.svh"

  // divisor never exceeds sqrt of the cofactor plus one
  localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an input transfer
  localparam logic [1:0] S_DIV  = 2'd1;  // division in flight
  localparam logic [1:0] S_DONE = 2'd2;  // result waiting for the output slot

  logic [1:0]             state_r, state_nxt;
  logic                   start_r, start_nxt;
  logic [VALUE_WIDTH-1:0] cof_r, cof_nxt;      // remaining cofactor
  logic [DIV_W-1:0]       dvs_r, dvs_nxt;      // trial divisor
  logic [MULT_W-1:0]      mult_r, mult_nxt;    // hits of the current divisor
  logic [TALLY_W-1:0]     tally_r, tally_nxt;  // distinct primes so far
  logic                   sqf_r, sqf_nxt;
  logic                   bound_r, bound_nxt;  // fresh divisor: check the sqrt bound
  logic                   zero_r, zero_nxt;    // input was zero
  logic                   least_r, least_nxt;  // input at or above the least sphenic
  logic [5:0]             res_r, res_nxt;      // packed result awaiting the output slot
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_dat_r, out_dat_nxt;

  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [DIV_W-1:0]       div_rem;

  logic                   in_xfer;
  logic                   out_free;
  logic                   quo_lt;
  logic                   rem_zero;
  logic [TALLY_W-1:0]     tally_fin;
  logic                   sqf_fin;
  logic                   sph_fin;

  snc_serdiv #(
    .VALUE_W (VALUE_WIDTH),
    .DIV_W   (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (cof_r),
    .divisor   (dvs_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // loop ends when the quotient drops below the divisor, i.e. d*d > cofactor
  assign quo_lt   = div_quo < {{(VALUE_WIDTH - DIV_W){1'b0}}, dvs_r};
  assign rem_zero = (div_rem == '0);

  // a leftover cofactor above one is one more prime
  assign tally_fin = tally_r + TALLY_W'(cof_r > VALUE_WIDTH'(1));
  assign sqf_fin   = sqf_r && !zero_r;
  assign sph_fin   = sqf_fin && least_r && (tally_fin == TALLY_W'(SPHENIC_PRIMES));

  always_comb begin
    state_nxt   = state_r;
    start_nxt   = 1'b0;
    cof_nxt     = cof_r;
    dvs_nxt     = dvs_r;
    mult_nxt    = mult_r;
    tally_nxt   = tally_r;
    sqf_nxt     = sqf_r;
    bound_nxt   = bound_r;
    zero_nxt    = zero_r;
    least_nxt   = least_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cof_nxt   = in_tdata[VALUE_WIDTH-1:0];
          dvs_nxt   = DIV_W'(FIRST_DIVISOR);
          mult_nxt  = '0;
          tally_nxt = '0;
          sqf_nxt   = 1'b1;
          bound_nxt = 1'b1;
          zero_nxt  = (in_tdata[VALUE_WIDTH-1:0] == '0);
          least_nxt = in_tdata[VALUE_WIDTH-1:0] >= VALUE_WIDTH'(LEAST_SPHENIC);
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (bound_r && quo_lt) begin
            res_nxt   = {tally_fin, sqf_fin, sph_fin};
            state_nxt = S_DONE;
          end else if (rem_zero) begin
            // divisor hit: divide it out and try it again
            cof_nxt   = div_quo;
            mult_nxt  = (mult_r == MULT_W'(MULT_MAX)) ? mult_r : mult_r + MULT_W'(1);
            bound_nxt = 1'b0;
            start_nxt = 1'b1;
          end else begin
            // divisor exhausted: fold its multiplicity in and step on
            if (mult_r >= MULT_W'(2)) begin
              sqf_nxt = 1'b0;
            end
            if (mult_r != '0) begin
              tally_nxt = tally_r + TALLY_W'(1);
            end
            mult_nxt  = '0;
            dvs_nxt   = dvs_r + DIV_W'(1);
            bound_nxt = 1'b1;
            start_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_dat_nxt = {2'b00, res_r};
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cof_r     <= cof_nxt;
    dvs_r     <= dvs_nxt;
    mult_r    <= mult_nxt;
    tally_r   <= tally_nxt;
    sqf_r     <= sqf_nxt;
    bound_r   <= bound_nxt;
    zero_r    <= zero_nxt;
    least_r   <= least_nxt;
    res_r     <= res_nxt;
    out_dat_r <= out_dat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // every input transfer kicks off a division on the next cycle
  `SNC_ASSERT_NEXT(a_start_after_xfer, in_xfer, start_r, "no divide start after input transfer")
  // divider only finishes while the sequencer waits for it
  `SNC_ASSERT_NOW(a_done_in_div, div_stat.done, state_r == S_DIV, "divider done outside S_DIV")
  // a new division only starts once the divider is idle
  `SNC_ASSERT_NOW(a_start_idle, start_r, !div_stat.busy, "divide start while divider busy")
  // trial divisor never falls below the first divisor during factoring
  `SNC_ASSERT_NOW(a_dvs_floor, state_r == S_DIV, dvs_r >= DIV_W'(FIRST_DIVISOR), "divisor below two")
  // a sphenic flag always comes with square-free and three primes
  `SNC_ASSERT_NOW(a_sph_consistent, out_vld_r && out_dat_r[0],
    out_dat_r[1] && (out_dat_r[5:2] == TALLY_W'(SPHENIC_PRIMES)), "inconsistent sphenic result")

endmodule

[rtl/core/snc_serdiv.sv]
module snc_serdiv #(
  parameter int VALUE_W = 32,
  parameter int DIV_W   = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [VALUE_W-1:0]   dividend,
  input  logic [DIV_W-1:0]     divisor,
  output snc_pkg::div_stat_t   stat,
  output logic [VALUE_W-1:0]   quotient,
  output logic [DIV_W-1:0]     remainder
);
  import snc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [VALUE_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     diff;
  logic               ge;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_r, quo_r[VALUE_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = CNT_W'(VALUE_W);
      busy_nxt = 1'b1;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_W-2:0], ge};
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
